### rtl/core/etlm_pkg.sv
// Shared types and constants for the event table list manager.
// Holds the command and status codes, the controller state type and the
// command/status structs between the controller and the datapath.
package etlm_pkg;

  // Command codes carried in the input word.
  typedef enum logic [1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_FREE   = 2'd1,
    CMD_INSERT = 2'd2,
    CMD_REMOVE = 2'd3
  } cmd_t;

  // Status codes returned in the result word.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;

  // Field widths of the stream words.
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned IDX_W   = 8;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned COUNT_W = 9;
  localparam int unsigned IN_W    = 16;
  localparam int unsigned OUT_W   = 24;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_READ,
    S_PH1,
    S_PH2
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic init_wr;   // write one entry of the clearing pass
    logic latch_in;  // capture the accepted input word
    logic rd_en;     // read the link and flag memories
    logic ph1;       // first write phase
    logic ph2;       // second write phase, list registers and result load
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic init_last; // clearing pass is at its last entry
    logic out_free;  // result register can take a new word
  } ctrl_stat_t;

endpackage

### rtl/core/etlm_ctrl.sv
// Controller state machine of the event table list manager.
// Depends on etlm_pkg for the state type and the command/status structs.
module etlm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  etlm_pkg::ctrl_stat_t stat,
  output etlm_pkg::ctrl_cmd_t  cmd
);

  etlm_pkg::state_t state;
  etlm_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= etlm_pkg::S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      etlm_pkg::S_INIT: begin
        if (stat.init_last) state_next = etlm_pkg::S_IDLE;
      end
      etlm_pkg::S_IDLE: begin
        if (s_tvalid) state_next = etlm_pkg::S_READ;
      end
      etlm_pkg::S_READ: state_next = etlm_pkg::S_PH1;
      etlm_pkg::S_PH1:  state_next = etlm_pkg::S_PH2;
      etlm_pkg::S_PH2: begin
        // The result can only be committed when the output register is free.
        if (stat.out_free) state_next = etlm_pkg::S_IDLE;
      end
      default: state_next = etlm_pkg::S_INIT;
    endcase
  end

  always_comb begin
    s_tready     = (state == etlm_pkg::S_IDLE);
    cmd.init_wr  = (state == etlm_pkg::S_INIT);
    cmd.latch_in = (state == etlm_pkg::S_IDLE) && s_tvalid;
    cmd.rd_en    = (state == etlm_pkg::S_READ);
    cmd.ph1      = (state == etlm_pkg::S_PH1);
    cmd.ph2      = (state == etlm_pkg::S_PH2) && stat.out_free;
  end

endmodule

### rtl/core/etlm_datapath.sv
// Datapath of the event table list manager: link and flag memories,
// list head/tail registers, free count and the result register.
// Depends on etlm_pkg; sequenced by etlm_ctrl.
module etlm_datapath #(
  parameter int NUM_ENTRIES = 256
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  etlm_pkg::ctrl_cmd_t                  cmd,
  output etlm_pkg::ctrl_stat_t                 stat,
  input  logic [etlm_pkg::CMD_W-1:0]           in_command,
  input  logic [etlm_pkg::IDX_W-1:0]           in_entry_index,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [etlm_pkg::STAT_W-1:0]          out_status,
  output logic [etlm_pkg::IDX_W-1:0]           out_allocated_index,
  output logic [etlm_pkg::COUNT_W-1:0]         out_free_count
);

  localparam int AW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int LW = $clog2(NUM_ENTRIES + 1);
  localparam logic [LW-1:0] NIL = LW'(NUM_ENTRIES);
  localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_ENTRIES - 1);

  // Flag bit 0 marks an allocated entry, bit 1 a queued entry.
  logic [LW-1:0] next_mem [NUM_ENTRIES];
  logic [LW-1:0] prev_mem [NUM_ENTRIES];
  logic [1:0]    flag_mem [NUM_ENTRIES];

  etlm_pkg::cmd_t          op;
  logic [etlm_pkg::IDX_W-1:0] idx;
  logic [AW-1:0]           init_cnt;
  logic [LW-1:0]           free_head, free_tail, used_head, used_tail, free_total;
  logic [LW-1:0]           free_head_next, free_tail_next, used_head_next, used_tail_next;
  logic [LW-1:0]           free_total_next;
  logic [LW-1:0]           rd_next, rd_prev;
  logic [1:0]              rd_flag;

  logic          idx_in, fh_in, pv_in, nx_in, ft_in, ut_in, ok;
  logic [1:0]    status;
  logic [LW-1:0] e_link;
  logic [AW-1:0] e_addr;

  logic          nx_we, pv_we, fl_we;
  logic [AW-1:0] nx_waddr, pv_waddr, fl_waddr;
  logic [LW-1:0] nx_wdata, pv_wdata;
  logic [1:0]    fl_wdata;

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op  <= etlm_pkg::cmd_t'(in_command);
      idx <= in_entry_index;
    end
  end

  always_comb begin
    idx_in = (32'(idx) < 32'(NUM_ENTRIES));
    fh_in  = (free_head < NIL);
    ft_in  = (free_tail < NIL);
    ut_in  = (used_tail < NIL);
    pv_in  = (rd_prev < NIL);
    nx_in  = (rd_next < NIL);
    e_link = (op == etlm_pkg::CMD_ALLOC) ? free_head : LW'(idx);
    e_addr = AW'(e_link);
    case (op)
      etlm_pkg::CMD_ALLOC: begin
        ok     = fh_in;
        status = fh_in ? etlm_pkg::ST_OK : etlm_pkg::ST_EMPTY;
      end
      etlm_pkg::CMD_FREE, etlm_pkg::CMD_INSERT: begin
        ok     = idx_in && rd_flag[0] && !rd_flag[1];
        status = ok ? etlm_pkg::ST_OK : etlm_pkg::ST_INVALID;
      end
      etlm_pkg::CMD_REMOVE: begin
        ok     = idx_in && rd_flag[0] && rd_flag[1];
        status = ok ? etlm_pkg::ST_OK : etlm_pkg::ST_INVALID;
      end
      default: begin
        ok     = 1'b0;
        status = etlm_pkg::ST_INVALID;
      end
    endcase
  end

  // Memory write ports: clearing pass, then two phases per command.
  always_comb begin
    nx_we = 1'b0; nx_waddr = '0; nx_wdata = '0;
    pv_we = 1'b0; pv_waddr = '0; pv_wdata = '0;
    fl_we = 1'b0; fl_waddr = '0; fl_wdata = '0;
    if (cmd.init_wr) begin
      nx_we = 1'b1; nx_waddr = init_cnt; nx_wdata = LW'(init_cnt) + LW'(1);
      pv_we = 1'b1; pv_waddr = init_cnt;
      pv_wdata = (init_cnt == '0) ? NIL : LW'(init_cnt) - LW'(1);
      fl_we = 1'b1; fl_waddr = init_cnt; fl_wdata = 2'b00;
    end else if (cmd.ph1 && ok) begin
      case (op)
        etlm_pkg::CMD_ALLOC: begin
          nx_we = 1'b1;  nx_waddr = e_addr;         nx_wdata = NIL;
          pv_we = nx_in; pv_waddr = AW'(rd_next);   pv_wdata = NIL;
          fl_we = 1'b1;  fl_waddr = e_addr;         fl_wdata = 2'b01;
        end
        etlm_pkg::CMD_FREE: begin
          nx_we = 1'b1; nx_waddr = e_addr; nx_wdata = NIL;
          pv_we = 1'b1; pv_waddr = e_addr; pv_wdata = free_tail;
          fl_we = 1'b1; fl_waddr = e_addr; fl_wdata = 2'b00;
        end
        etlm_pkg::CMD_INSERT: begin
          nx_we = 1'b1; nx_waddr = e_addr; nx_wdata = NIL;
          pv_we = 1'b1; pv_waddr = e_addr; pv_wdata = used_tail;
          fl_we = 1'b1; fl_waddr = e_addr; fl_wdata = 2'b11;
        end
        etlm_pkg::CMD_REMOVE: begin
          nx_we = pv_in; nx_waddr = AW'(rd_prev); nx_wdata = rd_next;
          pv_we = nx_in; pv_waddr = AW'(rd_next); pv_wdata = rd_prev;
          fl_we = 1'b1;  fl_waddr = e_addr;       fl_wdata = 2'b01;
        end
        default: ;
      endcase
    end else if (cmd.ph2 && ok) begin
      case (op)
        etlm_pkg::CMD_ALLOC: begin
          pv_we = 1'b1; pv_waddr = e_addr; pv_wdata = NIL;
        end
        etlm_pkg::CMD_FREE: begin
          nx_we = ft_in; nx_waddr = AW'(free_tail); nx_wdata = e_link;
        end
        etlm_pkg::CMD_INSERT: begin
          nx_we = ut_in; nx_waddr = AW'(used_tail); nx_wdata = e_link;
        end
        etlm_pkg::CMD_REMOVE: begin
          nx_we = 1'b1; nx_waddr = e_addr; nx_wdata = NIL;
          pv_we = 1'b1; pv_waddr = e_addr; pv_wdata = NIL;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (nx_we) next_mem[nx_waddr] <= nx_wdata;
    if (cmd.rd_en) rd_next <= next_mem[e_addr];
  end

  always_ff @(posedge clk) begin
    if (pv_we) prev_mem[pv_waddr] <= pv_wdata;
    if (cmd.rd_en) rd_prev <= prev_mem[e_addr];
  end

  always_ff @(posedge clk) begin
    if (fl_we) flag_mem[fl_waddr] <= fl_wdata;
    if (cmd.rd_en) rd_flag <= flag_mem[e_addr];
  end

  // List registers after the command; unchanged when it fails.
  always_comb begin
    free_head_next  = free_head;
    free_tail_next  = free_tail;
    used_head_next  = used_head;
    used_tail_next  = used_tail;
    free_total_next = free_total;
    if (ok) begin
      case (op)
        etlm_pkg::CMD_ALLOC: begin
          free_head_next = rd_next;
          if (!nx_in) free_tail_next = NIL;
          if (free_total != '0) free_total_next = free_total - LW'(1);
        end
        etlm_pkg::CMD_FREE: begin
          if (!ft_in) free_head_next = e_link;
          free_tail_next = e_link;
          if (free_total < NIL) free_total_next = free_total + LW'(1);
        end
        etlm_pkg::CMD_INSERT: begin
          if (!ut_in) used_head_next = e_link;
          used_tail_next = e_link;
        end
        etlm_pkg::CMD_REMOVE: begin
          if (!pv_in) used_head_next = rd_next;
          if (!nx_in) used_tail_next = rd_prev;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      init_cnt   <= '0;
      free_head  <= '0;
      free_tail  <= LW'(NUM_ENTRIES - 1);
      used_head  <= NIL;
      used_tail  <= NIL;
      free_total <= NIL;
    end else begin
      if (cmd.init_wr) init_cnt <= init_cnt + AW'(1);
      if (cmd.ph2) begin
        free_head  <= free_head_next;
        free_tail  <= free_tail_next;
        used_head  <= used_head_next;
        used_tail  <= used_tail_next;
        free_total <= free_total_next;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.ph2) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ph2) begin
      out_status          <= status;
      out_allocated_index <= (ok && op == etlm_pkg::CMD_ALLOC) ?
                             etlm_pkg::IDX_W'(free_head) : '0;
      out_free_count      <= etlm_pkg::COUNT_W'(free_total_next);
    end
  end

  always_comb begin
    stat.init_last = (init_cnt == LAST_ADDR);
    stat.out_free  = !m_tvalid || m_tready;
  end

endmodule

### rtl/core/event_table_list_manager_unit.sv
// Top level of the event table list manager.
// Depends on etlm_pkg, etlm_ctrl and etlm_datapath.
//
// The block keeps a table of NUM_ENTRIES timer event entries on two doubly
// linked lists, a free list and a used list, built from per-entry index links.
// Each input word on the s_ channel carries a command (allocate, free, insert
// into the used list, remove from the used list) and an entry index. Each
// input word produces exactly one result word on the m_ channel with a status,
// the index handed out by a successful allocate, and the free-list count.
//
// Every command passes through accept, a read of the link and flag memories and
// two write phases, since a remove updates both neighbors and then clears the
// entry's own links through link memories with a single write port. A new word is
// taken once the previous command has been committed to the result register.
//
// After reset the block runs a clearing pass over all NUM_ENTRIES entries that
// chains every entry onto the free list in order; s_tready stays low during it.
// If the receiver stalls, the finished result waits in the output register and
// the next word may still be accepted; that command then holds in its last
// phase until the output register is free, so no result is lost.
module event_table_list_manager_unit #(
  parameter int NUM_ENTRIES = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // s_tdata: [1:0] command, [9:2] entry_index, [15:10] zero.
  input  logic [etlm_pkg::IN_W-1:0]     s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // m_tdata: [1:0] status, [9:2] allocated_index, [18:10] free_count,
  // [23:19] zero.
  output logic [etlm_pkg::OUT_W-1:0]    m_tdata
);

  etlm_pkg::ctrl_cmd_t  cmd;
  etlm_pkg::ctrl_stat_t stat;

  logic [etlm_pkg::STAT_W-1:0]  status;
  logic [etlm_pkg::IDX_W-1:0]   allocated_index;
  logic [etlm_pkg::COUNT_W-1:0] free_count;

  etlm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  etlm_datapath #(
    .NUM_ENTRIES (NUM_ENTRIES)
  ) u_datapath (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .stat                (stat),
    .in_command          (s_tdata[1:0]),
    .in_entry_index      (s_tdata[9:2]),
    .m_tvalid            (m_tvalid),
    .m_tready            (m_tready),
    .out_status          (status),
    .out_allocated_index (allocated_index),
    .out_free_count      (free_count)
  );

  // Pack the result fields from the lowest bit up; the top bits are zero.
  assign m_tdata = {5'b0, free_count, allocated_index, status};

endmodule

### bench/event_table_list_manager_unit_checker.sv
// Checker for the event table list manager: watches both stream channels,
// keeps its own copy of the free and used lists and compares every result word.
// Depends on etlm_pkg for the command and status codes and the field widths.
module event_table_list_manager_unit_checker
  import etlm_pkg::*;
#(
  parameter int TABLE_SIZE = 256
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  input  logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,
  input  logic             m_tvalid,
  input  logic             m_tready,
  input  logic [OUT_W-1:0] m_tdata,
  output int               mismatch_count,
  output int               replies_pending
);

  localparam int LINK_W = $clog2(TABLE_SIZE) + 1;
  localparam logic [LINK_W-1:0] NIL = LINK_W'(TABLE_SIZE);

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [IDX_W-1:0]   granted;
    logic [COUNT_W-1:0] free_count;
  } list_reply_t;

  logic [LINK_W-1:0]  fwd_link [TABLE_SIZE];
  logic [LINK_W-1:0]  back_link[TABLE_SIZE];
  bit                 in_use   [TABLE_SIZE];
  bit                 on_used  [TABLE_SIZE];
  logic [LINK_W-1:0]  free_first, free_last, used_first, used_last;
  logic [COUNT_W-1:0] free_entries;

  list_reply_t awaited_replies[$];

  function automatic bit valid_link(logic [LINK_W-1:0] x);
    return x < TABLE_SIZE;
  endfunction

  // After reset every entry sits on the free list in index order.
  function automatic void clear_table();
    for (int i = 0; i < TABLE_SIZE; i++) begin
      fwd_link[i]  = (i + 1 < TABLE_SIZE) ? LINK_W'(i + 1) : NIL;
      back_link[i] = (i == 0) ? NIL : LINK_W'(i - 1);
      in_use[i]    = 1'b0;
      on_used[i]   = 1'b0;
    end
    free_first   = '0;
    free_last    = LINK_W'(TABLE_SIZE - 1);
    used_first   = NIL;
    used_last    = NIL;
    free_entries = COUNT_W'(TABLE_SIZE);
  endfunction

  // Applies one command to the shadow lists and returns the word it must give.
  function automatic list_reply_t apply_command(cmd_t op, logic [IDX_W-1:0] slot);
    list_reply_t       r;
    logic [LINK_W-1:0] e, pv, nx;
    r.status     = ST_OK;
    r.granted    = '0;
    e            = LINK_W'(slot);
    case (op)
      CMD_ALLOC: begin
        e = free_first;
        if (!valid_link(e)) begin
          r.status = ST_EMPTY;
        end else begin
          nx         = fwd_link[e];
          free_first = nx;
          if (valid_link(nx)) back_link[nx] = NIL;
          else free_last = NIL;
          if (free_entries > 0) free_entries--;
          fwd_link[e]  = NIL;
          back_link[e] = NIL;
          in_use[e]    = 1'b1;
          on_used[e]   = 1'b0;
          r.granted    = e[IDX_W-1:0];
        end
      end
      CMD_FREE: begin
        if (!valid_link(e) || !in_use[e] || on_used[e]) begin
          r.status = ST_INVALID;
        end else begin
          in_use[e]    = 1'b0;
          fwd_link[e]  = NIL;
          back_link[e] = NIL;
          if (valid_link(free_last)) begin
            fwd_link[free_last] = e;
            back_link[e]        = free_last;
          end else begin
            free_first = e;
          end
          free_last = e;
          if (free_entries < TABLE_SIZE) free_entries++;
        end
      end
      CMD_INSERT: begin
        if (!valid_link(e) || !in_use[e] || on_used[e]) begin
          r.status = ST_INVALID;
        end else begin
          fwd_link[e]  = NIL;
          back_link[e] = NIL;
          if (valid_link(used_last)) begin
            fwd_link[used_last] = e;
            back_link[e]        = used_last;
          end else begin
            used_first = e;
          end
          used_last  = e;
          on_used[e] = 1'b1;
        end
      end
      default: begin
        if (!valid_link(e) || !in_use[e] || !on_used[e]) begin
          r.status = ST_INVALID;
        end else begin
          pv = back_link[e];
          nx = fwd_link[e];
          if (valid_link(pv)) fwd_link[pv] = valid_link(nx) ? nx : NIL;
          else used_first = valid_link(nx) ? nx : NIL;
          if (valid_link(nx)) back_link[nx] = valid_link(pv) ? pv : NIL;
          else used_last = valid_link(pv) ? pv : NIL;
          fwd_link[e]  = NIL;
          back_link[e] = NIL;
          on_used[e]   = 1'b0;
        end
      end
    endcase
    r.free_count = free_entries;
    return r;
  endfunction

  task automatic note_mismatch(string what, list_reply_t want, list_reply_t seen);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t: %s: expected status %0d index %0d free %0d, got status %0d index %0d free %0d",
               $realtime, what, want.status, want.granted, want.free_count,
               seen.status, seen.granted, seen.free_count);
  endtask

  always @(posedge clk) begin
    list_reply_t seen, want;
    if (rst) begin
      clear_table();
      awaited_replies.delete();
      mismatch_count = 0;
    end else begin
      // The result side goes first: a word leaving now belongs to an older command.
      if (m_tvalid && m_tready) begin
        seen.status     = m_tdata[STAT_W-1:0];
        seen.granted    = m_tdata[STAT_W +: IDX_W];
        seen.free_count = m_tdata[STAT_W+IDX_W +: COUNT_W];
        if (awaited_replies.size() == 0) begin
          note_mismatch("result word with no command outstanding", '0, seen);
        end else begin
          want = awaited_replies.pop_front();
          if (seen.status !== want.status || seen.granted !== want.granted ||
              seen.free_count !== want.free_count)
            note_mismatch("result word differs", want, seen);
        end
      end
      if (s_tvalid && s_tready)
        awaited_replies.push_back(apply_command(cmd_t'(s_tdata[CMD_W-1:0]),
                                                s_tdata[CMD_W +: IDX_W]));
    end
    replies_pending <= awaited_replies.size();
  end

endmodule

### bench/event_table_list_manager_unit_test.sv
// Top of the event table list manager testbench: clock, reset, stimulus and
// the verdict. Depends on etlm_pkg, the block itself and the checker module.
module event_table_list_manager_unit_test;
  import etlm_pkg::*;

  localparam int TABLE_SIZE   = 256;
  localparam int ITEM_TARGET  = 1800;
  localparam int CYCLE_LIMIT  = 400000;
  // The receiver's one long hold-off starts at this cycle, well inside the
  // random part, and lasts long enough to back the block up into its input.
  localparam int HOLD_START   = 1500;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 32;

  // What the stimulus side believes each entry is doing. It mirrors only
  // which commands will succeed, so that most words are meaningful ones.
  typedef enum logic [1:0] {SLOT_FREE, SLOT_HELD, SLOT_QUEUED} slot_role_t;
  // Flavors of random traffic; each segment leans toward one list operation.
  typedef enum logic [1:0] {PLAN_GROW, PLAN_SHRINK, PLAN_CHURN, PLAN_MIXED} plan_t;

  logic             clk      = 1'b0;
  logic             rst      = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  // s_tdata: [1:0] command, [9:2] entry_index, [15:10] zero.
  logic [IN_W-1:0]  s_tdata  = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  // m_tdata: [1:0] status, [9:2] allocated_index, [18:10] free_count, [23:19] zero.
  logic [OUT_W-1:0] m_tdata;

  int mismatch_count;
  int replies_pending;
  int cycle_count = 0;
  int items_sent  = 0;
  int burst_left  = 0;

  slot_role_t role[TABLE_SIZE];
  int         free_order[$];
  int         used_order[$];

  always #1 clk = ~clk;

  event_table_list_manager_unit #(.NUM_ENTRIES(TABLE_SIZE)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  event_table_list_manager_unit_checker #(.TABLE_SIZE(TABLE_SIZE)) u_checker (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .mismatch_count  (mismatch_count),
    .replies_pending (replies_pending)
  );

  // Hard stop in case the block hangs; far above the slowest legal run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("event_table_list_manager_unit_test NOT OK");
      $finish;
    end
  end

  // Offers one word, called at a falling edge and returning at a falling edge.
  // The sender runs in bursts; between bursts tvalid drops for a random gap.
  // Long bursts now and then give stretches with no idling at all.
  task automatic send_word(cmd_t op, logic [IDX_W-1:0] slot);
    if (burst_left == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
    end
    burst_left--;
    s_tvalid = 1'b1;
    s_tdata  = {{(IN_W - CMD_W - IDX_W){1'b0}}, slot, op};
    do @(posedge clk); while (!s_tready);
    items_sent++;
    @(negedge clk);
  endtask

  // Updates the stimulus bookkeeping the way the block will, then sends.
  task automatic issue(cmd_t op, logic [IDX_W-1:0] slot);
    int pos;
    pos = 0;
    case (op)
      CMD_ALLOC: begin
        if (free_order.size() > 0) begin
          pos       = free_order.pop_front();
          role[pos] = SLOT_HELD;
        end
      end
      CMD_FREE: begin
        if (role[slot] == SLOT_HELD) begin
          role[slot] = SLOT_FREE;
          free_order.push_back(slot);
        end
      end
      CMD_INSERT: begin
        if (role[slot] == SLOT_HELD) begin
          role[slot] = SLOT_QUEUED;
          used_order.push_back(slot);
        end
      end
      default: begin
        if (role[slot] == SLOT_QUEUED) begin
          foreach (used_order[i]) if (used_order[i] == slot) pos = i;
          used_order.delete(pos);
          role[slot] = SLOT_HELD;
        end
      end
    endcase
    send_word(op, slot);
  endtask

  // Random entry in the given role, or -1 when there is none.
  function automatic int pick_slot(slot_role_t want);
    int cands[$];
    foreach (role[i]) if (role[i] == want) cands.push_back(i);
    if (cands.size() == 0) return -1;
    return cands[$urandom_range(0, cands.size() - 1)];
  endfunction

  // Any command on any entry. Half the time the entry is taken from a random
  // role, so frees and inserts of queued entries and the like turn up often.
  task automatic noise_item();
    int slot;
    slot = pick_slot(slot_role_t'($urandom_range(0, 2)));
    if (slot < 0 || $urandom_range(0, 1) == 1) slot = $urandom_range(0, TABLE_SIZE - 1);
    issue(cmd_t'($urandom_range(0, 3)), IDX_W'(slot));
  endtask

  task automatic random_item(plan_t plan);
    int roll, slot;
    int w_alloc, w_free, w_insert, w_remove;
    // Cumulative percentages; what is left over above w_remove is noise.
    case (plan)
      PLAN_GROW: begin
        w_alloc = 85; w_free = 85; w_insert = 90; w_remove = 90;
      end
      PLAN_SHRINK: begin
        w_alloc = 10; w_free = 55; w_insert = 60; w_remove = 90;
      end
      PLAN_CHURN: begin
        w_alloc = 15; w_free = 25; w_insert = 60; w_remove = 90;
      end
      default: begin
        w_alloc = 25; w_free = 45; w_insert = 65; w_remove = 85;
      end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < w_alloc) begin
      // The index field is ignored on allocate, so it carries random bits.
      issue(CMD_ALLOC, IDX_W'($urandom));
    end else if (roll < w_free) begin
      slot = pick_slot(SLOT_HELD);
      if (slot >= 0) issue(CMD_FREE, IDX_W'(slot));
      else noise_item();
    end else if (roll < w_insert) begin
      slot = pick_slot(SLOT_HELD);
      if (slot >= 0) issue(CMD_INSERT, IDX_W'(slot));
      else noise_item();
    end else if (roll < w_remove) begin
      if (used_order.size() > 0) begin
        // Unlink at the head, at the tail or anywhere in between.
        case ($urandom_range(0, 2))
          0: slot = used_order[0];
          1: slot = used_order[$];
          default: slot = used_order[$urandom_range(0, used_order.size() - 1)];
        endcase
        issue(CMD_REMOVE, IDX_W'(slot));
      end else begin
        noise_item();
      end
    end else begin
      noise_item();
    end
  endtask

  // Receiver: ready changes at the falling edge on a pattern of its own. The
  // pattern switches among always ready, mostly ready, ready two times in five and rarely ready,
  // and once holds off for a long stretch while the sender keeps going.
  initial begin
    int rx_cycle, mode_left, ready_pct;
    rx_cycle  = 0;
    mode_left = 0;
    ready_pct = 100;
    forever begin
      @(negedge clk);
      rx_cycle++;
      if (rx_cycle == HOLD_START) begin
        m_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (mode_left == 0) begin
        mode_left = $urandom_range(20, 120);
        case ($urandom_range(0, 3))
          0: ready_pct = 100;
          1: ready_pct = 70;
          2: ready_pct = 40;
          default: ready_pct = 15;
        endcase
      end
      mode_left--;
      m_tready = ($urandom_range(1, 100) <= ready_pct);
    end
  end

  initial begin
    plan_t plan;
    int    seg_left;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      role[i] = SLOT_FREE;
      free_order.push_back(i);
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part. An index outside the table cannot be encoded here, since
    // the 8-bit field covers all 256 entries exactly.
    issue(CMD_ALLOC, 8'hFF);        // hands out entry 0
    issue(CMD_ALLOC, 8'h00);        // entry 1
    issue(CMD_ALLOC, 8'hAA);        // entry 2
    issue(CMD_ALLOC, 8'h55);        // entry 3
    issue(CMD_FREE, 8'd255);        // entry never allocated
    issue(CMD_INSERT, 8'd255);      // insert of an unallocated entry
    issue(CMD_REMOVE, 8'd255);      // remove of an unqueued, unallocated entry
    issue(CMD_REMOVE, 8'd0);        // allocated but not queued
    issue(CMD_INSERT, 8'd0);
    issue(CMD_INSERT, 8'd1);
    issue(CMD_INSERT, 8'd2);
    issue(CMD_INSERT, 8'd3);
    issue(CMD_INSERT, 8'd1);        // already queued
    issue(CMD_FREE, 8'd1);          // free while still queued
    issue(CMD_REMOVE, 8'd2);        // middle of the used list
    issue(CMD_REMOVE, 8'd3);        // tail
    issue(CMD_REMOVE, 8'd0);        // head
    issue(CMD_REMOVE, 8'd1);        // the only entry left
    issue(CMD_REMOVE, 8'd1);        // no longer queued
    issue(CMD_FREE, 8'd1);          // goes to the free-list tail
    issue(CMD_FREE, 8'd1);          // double free
    issue(CMD_INSERT, 8'd1);        // insert after free
    issue(CMD_FREE, 8'd0);
    issue(CMD_FREE, 8'd2);
    issue(CMD_FREE, 8'd3);

    // Random part in segments. The first one grows the allocation far enough
    // to run the free list dry, so that empty allocates show up early.
    plan = PLAN_GROW;
    while (items_sent < ITEM_TARGET) begin
      seg_left = (plan == PLAN_GROW) ? $urandom_range(250, 400) : $urandom_range(100, 300);
      while (seg_left > 0 && items_sent < ITEM_TARGET) begin
        random_item(plan);
        seg_left--;
      end
      plan = plan_t'($urandom_range(0, 3));
    end
    s_tvalid = 1'b0;

    // Let every outstanding result drain, then keep the clock running so
    // that a stray extra word would still be caught by the checker.
    while (replies_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && replies_pending == 0) begin
      $display("event_table_list_manager_unit_test OK");
    end else begin
      $display("event_table_list_manager_unit_test NOT OK");
    end
    $finish;
  end

endmodule
